### rtl/jct_pkg.sv
// ----------------------------------------------------------------------------
// jct_pkg: shared types, constants and conversion functions
// Byte-level decode and re-encode steps for the Japanese code transcoder.
// ----------------------------------------------------------------------------
package jct_pkg;

    localparam int MAX_OUT  = 16;
    localparam int CNT_W    = $clog2(MAX_OUT + 1);
    localparam int IDX_W    = $clog2(MAX_OUT);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 3;

    typedef logic [2:0] t_code;

    localparam t_code CODE_NEW  = 3'd0;
    localparam t_code CODE_OLD  = 3'd1;
    localparam t_code CODE_NEC  = 3'd2;
    localparam t_code CODE_EUC  = 3'd3;
    localparam t_code CODE_SJIS = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDEN_KANA  = 2'd2;

    localparam logic [7:0] SS2_BYTE  = 8'd142;
    localparam logic [7:0] ESC_BYTE  = 8'd27;
    localparam logic [7:0] LF_BYTE   = 8'd10;
    localparam logic [7:0] CR_BYTE   = 8'd13;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PAREN  = 8'h28;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] CH_K      = 8'h4B;
    localparam logic [7:0] VOICED    = 8'd222;
    localparam logic [7:0] SEMI_VOICED = 8'd223;

    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_FIRST = 2'd1;
    localparam logic [1:0] ESC_SKIP  = 2'd2;

    localparam logic [1:0] VOICE_NONE = 2'd0;
    localparam logic [1:0] VOICE_DAKU = 2'd1;
    localparam logic [1:0] VOICE_HAN  = 2'd2;

    typedef logic [MAX_OUT-1:0][7:0] t_obytes;

    typedef struct packed {
        logic [7:0] lead_byte;
        logic       lead_held;
        logic [1:0] escape_phase;
        logic       source_two_byte;
        logic       target_two_byte;
        logic [7:0] kana_byte;
        logic       kana_held;
        logic       shift_two_seen;
    } t_state;

    typedef struct packed {
        t_state           st;
        t_code            src;
        t_code            tgt;
        logic             widen;
        t_obytes          bytes;
        logic [CNT_W-1:0] cnt;
    } t_ctx;

    // half-width kana to shift-jis full-width pair
    localparam logic [15:0] KANA_TAB [0:62] = '{
        {8'd129,8'd66},{8'd129,8'd117},{8'd129,8'd118},{8'd129,8'd65},{8'd129,8'd69},
        {8'd131,8'd146},{8'd131,8'd64},{8'd131,8'd66},{8'd131,8'd68},{8'd131,8'd70},
        {8'd131,8'd72},{8'd131,8'd131},{8'd131,8'd133},{8'd131,8'd135},{8'd131,8'd98},
        {8'd129,8'd91},{8'd131,8'd65},{8'd131,8'd67},{8'd131,8'd69},{8'd131,8'd71},
        {8'd131,8'd73},{8'd131,8'd74},{8'd131,8'd76},{8'd131,8'd78},{8'd131,8'd80},
        {8'd131,8'd82},{8'd131,8'd84},{8'd131,8'd86},{8'd131,8'd88},{8'd131,8'd90},
        {8'd131,8'd92},{8'd131,8'd94},{8'd131,8'd96},{8'd131,8'd99},{8'd131,8'd101},
        {8'd131,8'd103},{8'd131,8'd105},{8'd131,8'd106},{8'd131,8'd107},{8'd131,8'd108},
        {8'd131,8'd109},{8'd131,8'd110},{8'd131,8'd113},{8'd131,8'd116},{8'd131,8'd119},
        {8'd131,8'd122},{8'd131,8'd125},{8'd131,8'd126},{8'd131,8'd128},{8'd131,8'd129},
        {8'd131,8'd130},{8'd131,8'd132},{8'd131,8'd134},{8'd131,8'd136},{8'd131,8'd137},
        {8'd131,8'd138},{8'd131,8'd139},{8'd131,8'd140},{8'd131,8'd141},{8'd131,8'd143},
        {8'd131,8'd147},{8'd129,8'd74},{8'd129,8'd75}
    };

    function automatic t_code norm_code(t_code c);
        return (c > CODE_SJIS) ? CODE_SJIS : c;
    endfunction

    function automatic logic hankata(logic [7:0] b);
        return (b >= 8'd161) && (b <= 8'd223);
    endfunction

    function automatic logic iseuc(logic [7:0] b);
        return (b >= 8'd161) && (b <= 8'd254);
    endfunction

    function automatic logic sjis1(logic [7:0] b);
        return ((b >= 8'd129) && (b <= 8'd159)) || ((b >= 8'd224) && (b <= 8'd239));
    endfunction

    function automatic logic is_eol(logic [7:0] b);
        return (b == LF_BYTE) || (b == CR_BYTE);
    endfunction

    function automatic logic tgt_jis(t_ctx c);
        return c.tgt <= CODE_NEC;
    endfunction

    function automatic logic kana_wanted(t_ctx c);
        return tgt_jis(c) || c.widen;
    endfunction

    function automatic t_ctx put(t_ctx c, logic [7:0] b);
        if (c.cnt < CNT_W'(MAX_OUT)) begin
            c.bytes[c.cnt[IDX_W-1:0]] = b;
            c.cnt = c.cnt + 1'b1;
        end
        return c;
    endfunction

    function automatic t_ctx put_in_esc(t_ctx c);
        c = put(c, ESC_BYTE);
        if (c.tgt == CODE_NEC) begin
            c = put(c, CH_K);
        end else begin
            c = put(c, CH_DOLLAR);
            c = put(c, (c.tgt == CODE_OLD) ? CH_AT : CH_B);
        end
        return c;
    endfunction

    function automatic t_ctx put_out_esc(t_ctx c);
        c = put(c, ESC_BYTE);
        if (c.tgt == CODE_NEC) begin
            c = put(c, CH_H);
        end else begin
            c = put(c, CH_PAREN);
            c = put(c, CH_J);
        end
        return c;
    endfunction

    function automatic t_ctx open_kanji(t_ctx c);
        if (!c.st.target_two_byte) begin
            c.st.target_two_byte = 1'b1;
            c = put_in_esc(c);
        end
        return c;
    endfunction

    function automatic t_ctx close_kanji(t_ctx c);
        if (c.st.target_two_byte) begin
            c.st.target_two_byte = 1'b0;
            c = put_out_esc(c);
        end
        return c;
    endfunction

    // shift-jis pair to jis row and cell
    function automatic logic [15:0] to_jis(logic [7:0] c1, logic [7:0] c2);
        logic       adj;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] a;
        logic [7:0] b;
        adj  = (c2 < 8'd159);
        row  = (c1 < 8'd160) ? 8'd112 : 8'd176;
        col  = adj ? ((c2 > 8'd127) ? 8'd32 : 8'd31) : 8'd126;
        a    = 8'((c1 - row) << 1) - {7'd0, adj};
        b    = c2 - col;
        return {a, b};
    endfunction

    // jis row and cell to shift-jis pair
    function automatic logic [15:0] to_sjis(logic [7:0] c1, logic [7:0] c2);
        logic [8:0] h;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] a;
        logic [7:0] b;
        h    = ({1'b0, c1} + 9'd1) >> 1;
        row  = (c1 < 8'd95) ? 8'd112 : 8'd176;
        col  = c1[0] ? ((c2 > 8'd95) ? 8'd32 : 8'd31) : 8'd126;
        a    = h[7:0] + row;
        b    = c2 + col;
        return {a, b};
    endfunction

    function automatic logic [1:0] voice_of(logic [7:0] k, logic [7:0] m);
        logic maru;
        logic nigori;
        maru   = (k >= 8'd202) && (k <= 8'd206);
        nigori = ((k >= 8'd182) && (k <= 8'd196)) || maru || (k == 8'd179);
        if ((m == VOICED) && nigori) return VOICE_DAKU;
        if ((m == SEMI_VOICED) && maru) return VOICE_HAN;
        return VOICE_NONE;
    endfunction

    function automatic t_ctx emit_kana(t_ctx c, logic [7:0] k, logic [1:0] voice);
        logic [5:0]  idx;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [15:0] p;
        idx = hankata(k) ? 6'(k - 8'd161) : 6'd0;
        a   = KANA_TAB[idx][15:8];
        b   = KANA_TAB[idx][7:0];
        if (voice == VOICE_DAKU) begin
            if (((b >= 8'd74) && (b <= 8'd103)) || ((b >= 8'd110) && (b <= 8'd122))) begin
                b = b + 8'd1;
            end else if ((a == 8'd131) && (b == 8'd69)) begin
                b = 8'd148;
            end
        end else if ((voice == VOICE_HAN) && (b >= 8'd110) && (b <= 8'd122)) begin
            b = b + 8'd2;
        end
        if (c.tgt <= CODE_NEC) begin
            p = to_jis(a, b);
            a = p[15:8];
            b = p[7:0];
            c = open_kanji(c);
        end else if (c.tgt == CODE_EUC) begin
            p = to_jis(a, b);
            a = p[15:8] + 8'd128;
            b = p[7:0] + 8'd128;
        end
        c = put(c, a);
        c = put(c, b);
        return c;
    endfunction

    function automatic t_ctx process_seven(t_ctx c, logic [7:0] b);
        logic [7:0]  a;
        logic [7:0]  cc;
        logic [15:0] p;
        logic        nw;
        logic        change;
        if (c.st.lead_held) begin
            a  = c.st.lead_byte;
            cc = b;
            c.st.lead_held = 1'b0;
            if (c.tgt == CODE_EUC) begin
                a  = a + 8'd128;
                cc = cc + 8'd128;
            end else if (c.tgt == CODE_SJIS) begin
                p  = to_sjis(a, cc);
                a  = p[15:8];
                cc = p[7:0];
            end
            c = put(c, a);
            c = put(c, cc);
            return c;
        end
        if (c.st.escape_phase == ESC_FIRST) begin
            nw     = (b == CH_K) || (b == CH_DOLLAR);
            change = (nw != c.st.source_two_byte);
            c.st.escape_phase = ((b == CH_DOLLAR) || (b == CH_PAREN)) ? ESC_SKIP : ESC_NONE;
            c.st.source_two_byte = nw;
            if (tgt_jis(c)) begin
                c.st.target_two_byte = nw;
                if (change) begin
                    if (nw) c = put_in_esc(c);
                    else    c = put_out_esc(c);
                end
            end
            return c;
        end
        if (c.st.escape_phase != ESC_NONE) begin
            c.st.escape_phase = ESC_NONE;
            return c;
        end
        if (b == ESC_BYTE) begin
            c.st.escape_phase = ESC_FIRST;
            return c;
        end
        if (is_eol(b)) begin
            if (tgt_jis(c)) c = close_kanji(c);
            c.st.source_two_byte = 1'b0;
            c = put(c, b);
            return c;
        end
        if (c.st.source_two_byte) begin
            c.st.lead_byte = b;
            c.st.lead_held = 1'b1;
            return c;
        end
        c = put(c, b);
        return c;
    endfunction

    function automatic t_ctx process_sjis(t_ctx c, logic [7:0] b);
        logic [7:0]  a;
        logic [7:0]  cc;
        logic [15:0] p;
        logic        ok;
        if (c.st.lead_held) begin
            a  = c.st.lead_byte;
            cc = b;
            ok = (b >= 8'd64) && (b <= 8'd252);
            c.st.lead_held = 1'b0;
            if (c.tgt <= CODE_NEC) begin
                if (ok) begin
                    p  = to_jis(a, cc);
                    a  = p[15:8];
                    cc = p[7:0];
                    c  = open_kanji(c);
                end
            end else if (c.tgt == CODE_EUC) begin
                if (ok) begin
                    p  = to_jis(a, cc);
                    a  = p[15:8] + 8'd128;
                    cc = p[7:0] + 8'd128;
                end
            end else if (!ok) begin
                return c;
            end
            c = put(c, a);
            c = put(c, cc);
            return c;
        end
        if (tgt_jis(c) && is_eol(b)) begin
            c = close_kanji(c);
            c = put(c, b);
            return c;
        end
        if (sjis1(b)) begin
            c.st.lead_byte = b;
            c.st.lead_held = 1'b1;
            return c;
        end
        if (hankata(b)) begin
            if (kana_wanted(c)) begin
                c.st.kana_byte = b;
                c.st.kana_held = 1'b1;
                return c;
            end
            if (c.tgt == CODE_EUC) c = put(c, SS2_BYTE);
            c = put(c, b);
            return c;
        end
        if (tgt_jis(c)) c = close_kanji(c);
        c = put(c, b);
        return c;
    endfunction

    function automatic t_ctx process_euc(t_ctx c, logic [7:0] b);
        logic [7:0]  a;
        logic [7:0]  cc;
        logic [15:0] p;
        if (c.st.lead_held) begin
            a  = c.st.lead_byte;
            cc = b;
            c.st.lead_held = 1'b0;
            if (a == SS2_BYTE) begin
                if (hankata(b)) begin
                    if (kana_wanted(c)) begin
                        c.st.kana_byte = b;
                        c.st.kana_held = 1'b1;
                        return c;
                    end
                    if (c.tgt == CODE_SJIS) begin
                        c = put(c, b);
                        return c;
                    end
                end
                c = put(c, SS2_BYTE);
                c = put(c, b);
                return c;
            end
            if (iseuc(b)) begin
                if (c.tgt <= CODE_NEC) begin
                    a  = a - 8'd128;
                    cc = cc - 8'd128;
                    c  = open_kanji(c);
                end else if (c.tgt == CODE_SJIS) begin
                    p  = to_sjis(a - 8'd128, cc - 8'd128);
                    a  = p[15:8];
                    cc = p[7:0];
                end
            end else if (c.tgt == CODE_EUC) begin
                return c;
            end
            c = put(c, a);
            c = put(c, cc);
            return c;
        end
        if (tgt_jis(c) && is_eol(b)) begin
            c = close_kanji(c);
            c = put(c, b);
            return c;
        end
        if (iseuc(b) || (b == SS2_BYTE)) begin
            c.st.lead_byte = b;
            c.st.lead_held = 1'b1;
            return c;
        end
        if (tgt_jis(c)) c = close_kanji(c);
        c = put(c, b);
        return c;
    endfunction

    function automatic t_ctx process_byte(t_ctx c, logic [7:0] b);
        if (c.src <= CODE_NEC) return process_seven(c, b);
        if (c.src == CODE_EUC) return process_euc(c, b);
        return process_sjis(c, b);
    endfunction

    function automatic t_ctx take_byte(t_ctx c, logic [7:0] b);
        logic [7:0] k;
        logic [1:0] v;
        k = c.st.kana_byte;
        if (!c.st.kana_held) return process_byte(c, b);
        if (!c.st.shift_two_seen && (c.src == CODE_EUC) && (b == SS2_BYTE)) begin
            c.st.shift_two_seen = 1'b1;
            return c;
        end
        c.st.kana_held = 1'b0;
        v = voice_of(k, b);
        if (v != VOICE_NONE) begin
            c.st.shift_two_seen = 1'b0;
            return emit_kana(c, k, v);
        end
        c = emit_kana(c, k, VOICE_NONE);
        if (c.st.shift_two_seen) begin
            c.st.shift_two_seen = 1'b0;
            c = process_byte(c, SS2_BYTE);
        end
        return process_byte(c, b);
    endfunction

    function automatic t_ctx finish_text(t_ctx c);
        logic drop;
        if (c.st.kana_held) begin
            c.st.kana_held = 1'b0;
            c = emit_kana(c, c.st.kana_byte, VOICE_NONE);
            if (c.st.shift_two_seen) begin
                c.st.shift_two_seen = 1'b0;
                c = process_byte(c, SS2_BYTE);
            end
        end
        if (c.st.lead_held) begin
            drop = ((c.src == CODE_SJIS) && (c.tgt == CODE_SJIS)) ||
                   ((c.src == CODE_EUC) && (c.tgt == CODE_EUC) &&
                    (c.st.lead_byte != SS2_BYTE));
            if (!drop) c = put(c, c.st.lead_byte);
        end
        if (tgt_jis(c) && c.st.target_two_byte) c = put_out_esc(c);
        c.st = '0;
        return c;
    endfunction

endpackage

### rtl/jct_if.sv
// ----------------------------------------------------------------------------
// jct_if: channel interfaces
// Input byte, output byte and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface jct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_end;

    modport source (output valid, output in_byte, output in_end, input ready);
    modport sink   (input valid, input in_byte, input in_end, output ready);
endinterface

interface jct_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface jct_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [jct_pkg::CFG_IDX_W-1:0]    index;
    logic [jct_pkg::CFG_DAT_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/japanese_code_transcoder.sv
// ----------------------------------------------------------------------------
// japanese_code_transcoder: Shift-JIS / EUC-JP / seven-bit JIS converter
// Converts one source byte per transfer into zero or more output bytes.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload               transfer when
//   i_in     in         in_byte, in_end       i_in.valid  & i_in.ready
//   o_out    out        out_byte, out_last    o_out.valid & o_out.ready
//   i_cfg    in         index, data           i_cfg.valid & i_cfg.ready
//
// an input byte is decoded in the cycle it is taken; its results land in a
// 16-byte output register that drains one byte per cycle while o_out.ready is high
// items giving zero or one byte run at one per cycle unless the output stalls;
// a longer item holds new input off until its last byte leaves the output port
// reset (synchronous, active low) clears the conversion state and sets the
// codes to Shift-JIS in and out, kana widening off
// an output stall holds i_in.ready low while the register holds any byte; a
// new byte is taken when it is empty or its last byte leaves in that cycle;
// the config channel is always ready
module japanese_code_transcoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jct_in_if.sink      i_in,
    jct_out_if.source   o_out,
    jct_cfg_if.sink     i_cfg
);

    // configuration registers
    jct_pkg::t_code r_source_code;
    jct_pkg::t_code r_target_code;
    logic           r_widen_kana;

    // conversion state
    jct_pkg::t_state r_state;
    jct_pkg::t_state n_state;

    // output register: byte 0 is presented, shifts down on each output transfer
    jct_pkg::t_obytes                r_buf;
    jct_pkg::t_obytes                n_buf;
    logic [jct_pkg::CNT_W-1:0]       r_cnt;
    logic [jct_pkg::CNT_W-1:0]       n_cnt;

    jct_pkg::t_ctx w_ctx_in;
    jct_pkg::t_ctx w_ctx_out;

    logic w_in_xfer;
    logic w_out_xfer;

    // take a new byte when the register is empty or its last byte leaves now
    assign i_in.ready = (r_cnt == '0) ||
                        ((r_cnt == jct_pkg::CNT_W'(1)) && o_out.ready);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid    = (r_cnt != '0);
    assign o_out.out_byte = r_buf[0];
    assign o_out.out_last = (r_cnt == jct_pkg::CNT_W'(1));

    assign w_in_xfer  = i_in.valid & i_in.ready;
    assign w_out_xfer = o_out.valid & o_out.ready;

    // single-pass decode of the current byte against the held state
    always_comb begin
        w_ctx_in.st    = r_state;
        w_ctx_in.src   = jct_pkg::norm_code(r_source_code);
        w_ctx_in.tgt   = jct_pkg::norm_code(r_target_code);
        w_ctx_in.widen = r_widen_kana;
        w_ctx_in.bytes = '0;
        w_ctx_in.cnt   = '0;
        if (i_in.in_end) begin
            w_ctx_out = jct_pkg::finish_text(w_ctx_in);
        end else begin
            w_ctx_out = jct_pkg::take_byte(w_ctx_in, i_in.in_byte);
        end
    end

    always_comb begin
        n_state = r_state;
        n_buf   = r_buf;
        n_cnt   = r_cnt;
        if (w_in_xfer) begin
            n_state = w_ctx_out.st;
            n_buf   = w_ctx_out.bytes;
            n_cnt   = w_ctx_out.cnt;
        end else if (w_out_xfer) begin
            n_buf = r_buf >> 8;
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        if (!i_rst_n) begin
            r_state <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // register writes; an unused index is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_code <= jct_pkg::CODE_SJIS;
            r_target_code <= jct_pkg::CODE_SJIS;
            r_widen_kana  <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                jct_pkg::REG_SOURCE_CODE: r_source_code <= i_cfg.data;
                jct_pkg::REG_TARGET_CODE: r_target_code <= i_cfg.data;
                jct_pkg::REG_WIDEN_KANA:  r_widen_kana  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

endmodule

### rtl/jct_checker.sv
// ----------------------------------------------------------------------------
// jct_checker: port-level assertions
// Watches the handshakes of the transcoder top level.
// ----------------------------------------------------------------------------
module jct_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last,
    input logic       i_cfg_ready
);

    // stalled output keeps its byte
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
                                        && $stable(i_out_last))
        else $error("output changed while stalled");

    // a stalled output blocks new input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken over a stalled output");

    // empty output register always takes input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("idle block not ready");

    // config port never stalls
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("config port stalled");

endmodule

bind japanese_code_transcoder jct_checker u_jct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.out_last),
    .i_cfg_ready (i_cfg.ready)
);

### bench/tb_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_channels: bench-side notes for the transcoder channels
// The channel interfaces come from the rtl; this file only carries the
// bench's shared constants.
// ----------------------------------------------------------------------------
package tb_jct_pkg;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF_CYCLES = 300;
endpackage

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the japanese code transcoder
// Drives directed and random byte streams under several code settings,
// predicts output bytes with an independent conversion model and compares
// every output transfer in order.
// ----------------------------------------------------------------------------
module tb;
    localparam logic [7:0] B_ESC = 8'd27;
    localparam logic [7:0] B_LF  = 8'd10;
    localparam logic [7:0] B_CR  = 8'd13;
    localparam logic [7:0] B_SS2 = 8'd142;
    localparam logic [7:0] B_DAKU = 8'd222;
    localparam logic [7:0] B_HAN  = 8'd223;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #2 i_clk = ~i_clk;

    jct_in_if  in_ch();
    jct_out_if out_ch();
    jct_cfg_if cfg_ch();

    japanese_code_transcoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // expected output byte with its last flag
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_exp_byte;

    t_exp_byte expected_bytes[$];
    int errors = 0;
    int bytes_checked = 0;
    int items_sent = 0;
    int idle_cycles = 0;

    // --------------------------------------------------------------------
    // conversion model state
    // --------------------------------------------------------------------
    jct_pkg::t_code m_src = jct_pkg::CODE_SJIS;
    jct_pkg::t_code m_tgt = jct_pkg::CODE_SJIS;
    logic       m_widen = 1'b0;
    logic [7:0] m_lead;
    logic       m_lead_held;
    logic [1:0] m_esc;
    logic       m_src_kanji;
    logic       m_tgt_kanji;
    logic [7:0] m_kana;
    logic       m_kana_held;
    logic       m_ss2_seen;
    logic [7:0] step_bytes[$];

    // full-width pairs in shift-jis for kana 161..223
    logic [7:0] wide_hi[0:62];
    logic [7:0] wide_lo[0:62];

    initial begin
        int lo[0:62];
        int hi0[0:62];
        lo = '{66,117,118,65,69,146,64,66,68,70,72,131,133,135,98,91,65,67,69,71,
               73,74,76,78,80,82,84,86,88,90,92,94,96,99,101,103,105,106,107,108,
               109,110,113,116,119,122,125,126,128,129,130,132,134,136,137,138,139,
               140,141,143,147,74,75};
        for (int i = 0; i < 63; i++) begin
            hi0[i] = 131;
        end
        hi0[0] = 129; hi0[1] = 129; hi0[2] = 129; hi0[3] = 129; hi0[4] = 129;
        hi0[15] = 129; hi0[61] = 129; hi0[62] = 129;
        for (int i = 0; i < 63; i++) begin
            wide_hi[i] = 8'(hi0[i]);
            wide_lo[i] = 8'(lo[i]);
        end
    end

    function automatic jct_pkg::t_code eff(jct_pkg::t_code c);
        return (c > jct_pkg::CODE_SJIS) ? jct_pkg::CODE_SJIS : c;
    endfunction

    function automatic logic out_jis();
        return eff(m_tgt) <= jct_pkg::CODE_NEC;
    endfunction

    function automatic logic is_kana(logic [7:0] b);
        return b >= 161 && b <= 223;
    endfunction

    function automatic logic is_euc_byte(logic [7:0] b);
        return b >= 161 && b <= 254;
    endfunction

    function automatic logic is_sjis_lead(logic [7:0] b);
        return (b >= 129 && b <= 159) || (b >= 224 && b <= 239);
    endfunction

    task automatic emit(logic [7:0] b);
        if (step_bytes.size() < 16) step_bytes.push_back(b);
    endtask

    task automatic emit_kanji_in();
        emit(B_ESC);
        if (eff(m_tgt) == jct_pkg::CODE_NEC) emit("K");
        else begin
            emit("$");
            emit(eff(m_tgt) == jct_pkg::CODE_OLD ? "@" : "B");
        end
    endtask

    task automatic emit_kanji_out();
        emit(B_ESC);
        if (eff(m_tgt) == jct_pkg::CODE_NEC) emit("H");
        else begin
            emit("(");
            emit("J");
        end
    endtask

    task automatic enter_kanji();
        if (!m_tgt_kanji) begin
            m_tgt_kanji = 1'b1;
            emit_kanji_in();
        end
    endtask

    task automatic leave_kanji();
        if (m_tgt_kanji) begin
            m_tgt_kanji = 1'b0;
            emit_kanji_out();
        end
    endtask

    // shift-jis pair to jis row/cell
    task automatic sjis_to_jis(inout logic [7:0] a, inout logic [7:0] b);
        logic       adj;
        logic [7:0] row;
        logic [7:0] col;
        adj  = b < 159;
        row  = a < 160 ? 8'd112 : 8'd176;
        col  = adj ? (b > 127 ? 8'd32 : 8'd31) : 8'd126;
        a = 8'(((a - row) << 1) - adj);
        b = b - col;
    endtask

    task automatic jis_to_sjis(inout logic [7:0] a, inout logic [7:0] b);
        logic [8:0] h;
        logic [7:0] col;
        col = a[0] ? (b > 95 ? 8'd32 : 8'd31) : 8'd126;
        h = ({1'b0, a} + 9'd1) >> 1;
        b = b + col;
        a = h[7:0] + (a < 95 ? 8'd112 : 8'd176);
    endtask

    // plain, voiced or semi-voiced
    function automatic logic [1:0] mark_kind(logic [7:0] k, logic [7:0] m);
        logic maru;
        logic nigori;
        maru   = k >= 202 && k <= 206;
        nigori = (k >= 182 && k <= 196) || maru || k == 179;
        if (m == B_DAKU && nigori) return jct_pkg::VOICE_DAKU;
        if (m == B_HAN && maru) return jct_pkg::VOICE_HAN;
        return jct_pkg::VOICE_NONE;
    endfunction

    task automatic widen(logic [7:0] k, logic [1:0] mark);
        logic [7:0] a;
        logic [7:0] b;
        int idx;
        idx = is_kana(k) ? k - 161 : 0;
        a = wide_hi[idx];
        b = wide_lo[idx];
        if (mark == jct_pkg::VOICE_DAKU) begin
            if ((b >= 74 && b <= 103) || (b >= 110 && b <= 122)) b = b + 8'd1;
            else if (a == 131 && b == 69) b = 8'd148;
        end else if (mark == jct_pkg::VOICE_HAN && b >= 110 && b <= 122) begin
            b = b + 8'd2;
        end
        if (eff(m_tgt) <= jct_pkg::CODE_NEC) begin
            sjis_to_jis(a, b);
            enter_kanji();
        end else if (eff(m_tgt) == jct_pkg::CODE_EUC) begin
            sjis_to_jis(a, b);
            a = a + 8'd128;
            b = b + 8'd128;
        end
        emit(a);
        emit(b);
    endtask

    function automatic logic want_wide();
        return out_jis() || m_widen;
    endfunction

    task automatic seven_bit_byte(logic [7:0] b);
        logic [7:0] a;
        logic [7:0] c;
        logic       two;
        logic       changed;
        if (m_lead_held) begin
            a = m_lead;
            c = b;
            m_lead_held = 1'b0;
            if (eff(m_tgt) == jct_pkg::CODE_EUC) begin
                a = a + 8'd128;
                c = c + 8'd128;
            end else if (eff(m_tgt) == jct_pkg::CODE_SJIS) begin
                jis_to_sjis(a, c);
            end
            emit(a);
            emit(c);
        end else if (m_esc == jct_pkg::ESC_FIRST) begin
            two = (b == "K" || b == "$");
            changed = two != m_src_kanji;
            m_esc = (b == "$" || b == "(") ? jct_pkg::ESC_SKIP : jct_pkg::ESC_NONE;
            m_src_kanji = two;
            if (out_jis()) begin
                m_tgt_kanji = two;
                if (changed) begin
                    if (two) emit_kanji_in();
                    else emit_kanji_out();
                end
            end
        end else if (m_esc != jct_pkg::ESC_NONE) begin
            m_esc = jct_pkg::ESC_NONE;
        end else if (b == B_ESC) begin
            m_esc = jct_pkg::ESC_FIRST;
        end else if (b == B_LF || b == B_CR) begin
            if (out_jis()) leave_kanji();
            m_src_kanji = 1'b0;
            emit(b);
        end else if (m_src_kanji) begin
            m_lead = b;
            m_lead_held = 1'b1;
        end else begin
            emit(b);
        end
    endtask

    task automatic sjis_byte(logic [7:0] b);
        logic [7:0] a;
        logic [7:0] c;
        logic       ok;
        if (m_lead_held) begin
            a = m_lead;
            c = b;
            ok = b >= 64 && b <= 252;
            m_lead_held = 1'b0;
            if (eff(m_tgt) <= jct_pkg::CODE_NEC) begin
                if (ok) begin
                    sjis_to_jis(a, c);
                    enter_kanji();
                end
            end else if (eff(m_tgt) == jct_pkg::CODE_EUC) begin
                if (ok) begin
                    sjis_to_jis(a, c);
                    a = a + 8'd128;
                    c = c + 8'd128;
                end
            end else if (!ok) begin
                return;
            end
            emit(a);
            emit(c);
        end else if (out_jis() && (b == B_LF || b == B_CR)) begin
            leave_kanji();
            emit(b);
        end else if (is_sjis_lead(b)) begin
            m_lead = b;
            m_lead_held = 1'b1;
        end else if (is_kana(b)) begin
            if (want_wide()) begin
                m_kana = b;
                m_kana_held = 1'b1;
            end else begin
                if (eff(m_tgt) == jct_pkg::CODE_EUC) emit(B_SS2);
                emit(b);
            end
        end else begin
            if (out_jis()) leave_kanji();
            emit(b);
        end
    endtask

    task automatic euc_byte(logic [7:0] b);
        logic [7:0] a;
        logic [7:0] c;
        if (m_lead_held) begin
            a = m_lead;
            c = b;
            m_lead_held = 1'b0;
            if (a == B_SS2) begin
                if (is_kana(b)) begin
                    if (want_wide()) begin
                        m_kana = b;
                        m_kana_held = 1'b1;
                        return;
                    end
                    if (eff(m_tgt) == jct_pkg::CODE_SJIS) begin
                        emit(b);
                        return;
                    end
                end
                emit(B_SS2);
                emit(b);
                return;
            end
            if (is_euc_byte(b)) begin
                if (eff(m_tgt) <= jct_pkg::CODE_NEC) begin
                    a = a - 8'd128;
                    c = c - 8'd128;
                    enter_kanji();
                end else if (eff(m_tgt) == jct_pkg::CODE_SJIS) begin
                    a = a - 8'd128;
                    c = c - 8'd128;
                    jis_to_sjis(a, c);
                end
            end else if (eff(m_tgt) == jct_pkg::CODE_EUC) begin
                return;
            end
            emit(a);
            emit(c);
        end else if (out_jis() && (b == B_LF || b == B_CR)) begin
            leave_kanji();
            emit(b);
        end else if (is_euc_byte(b) || b == B_SS2) begin
            m_lead = b;
            m_lead_held = 1'b1;
        end else begin
            if (out_jis()) leave_kanji();
            emit(b);
        end
    endtask

    task automatic decode(logic [7:0] b);
        if (eff(m_src) <= jct_pkg::CODE_NEC) seven_bit_byte(b);
        else if (eff(m_src) == jct_pkg::CODE_EUC) euc_byte(b);
        else sjis_byte(b);
    endtask

    task automatic clear_text_state();
        m_lead = '0;
        m_lead_held = 1'b0;
        m_esc = jct_pkg::ESC_NONE;
        m_src_kanji = 1'b0;
        m_tgt_kanji = 1'b0;
        m_kana = '0;
        m_kana_held = 1'b0;
        m_ss2_seen = 1'b0;
    endtask

    // works out the bytes one input transfer produces, queues them
    task automatic predict_transfer(logic [7:0] b, logic fin);
        logic [1:0] mk;
        logic drop;
        step_bytes.delete();
        if (fin) begin
            if (m_kana_held) begin
                m_kana_held = 1'b0;
                widen(m_kana, jct_pkg::VOICE_NONE);
                if (m_ss2_seen) begin
                    m_ss2_seen = 1'b0;
                    decode(B_SS2);
                end
            end
            if (m_lead_held) begin
                drop = (eff(m_src) == jct_pkg::CODE_SJIS &&
                        eff(m_tgt) == jct_pkg::CODE_SJIS) ||
                       (eff(m_src) == jct_pkg::CODE_EUC &&
                        eff(m_tgt) == jct_pkg::CODE_EUC && m_lead != B_SS2);
                if (!drop) emit(m_lead);
            end
            if (out_jis() && m_tgt_kanji) emit_kanji_out();
            clear_text_state();
        end else if (!m_kana_held) begin
            decode(b);
        end else if (!m_ss2_seen && eff(m_src) == jct_pkg::CODE_EUC && b == B_SS2) begin
            // kana waiting: a shift-two may precede the mark
            m_ss2_seen = 1'b1;
        end else begin
            m_kana_held = 1'b0;
            mk = mark_kind(m_kana, b);
            if (mk != jct_pkg::VOICE_NONE) begin
                m_ss2_seen = 1'b0;
                widen(m_kana, mk);
            end else begin
                widen(m_kana, jct_pkg::VOICE_NONE);
                if (m_ss2_seen) begin
                    m_ss2_seen = 1'b0;
                    decode(B_SS2);
                end
                decode(b);
            end
        end
        foreach (step_bytes[i]) begin
            expected_bytes.push_back('{step_bytes[i], i == step_bytes.size() - 1});
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch %0s: got %0d expected %0d (byte %0d)", what, got, want,
                 bytes_checked);
    endtask

    // --------------------------------------------------------------------
    // output side: random stalls, one long hold-off
    // --------------------------------------------------------------------
    logic quiet_phase = 1'b0;
    logic hold_off = 1'b0;

    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) out_ch.ready <= 1'b0;
            else out_ch.ready <= quiet_phase || ($urandom_range(99) >= 12);
        end
    end

    // checker on output transfers
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("unexpected byte", out_ch.out_byte, -1);
            end else begin
                t_exp_byte e;
                e = expected_bytes.pop_front();
                if (out_ch.out_byte !== e.data)
                    report_mismatch("out_byte", out_ch.out_byte, e.data);
                if (out_ch.out_last !== e.last)
                    report_mismatch("out_last", out_ch.out_last, e.last);
            end
            bytes_checked++;
        end
    end

    // watchdog on cycles with no input or output transfer
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= tb_jct_pkg::WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d bytes outstanding",
                         expected_bytes.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // --------------------------------------------------------------------
    // input side
    // --------------------------------------------------------------------
    // sends one item; prediction happens at the transfer edge
    task automatic send_item(logic [7:0] b, logic fin);
        while (!quiet_phase && $urandom_range(99) < 12) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_end  <= fin;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_transfer(b, fin);
        items_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // register write while idle; the caller drops valid after the last one
    task automatic write_reg(logic [1:0] idx, logic [2:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            jct_pkg::REG_SOURCE_CODE: m_src = val;
            jct_pkg::REG_TARGET_CODE: m_tgt = val;
            jct_pkg::REG_WIDEN_KANA:  m_widen = val[0];
            default: ;
        endcase
    endtask

    task automatic set_codes(jct_pkg::t_code s, jct_pkg::t_code t, logic w);
        drain();
        write_reg(jct_pkg::REG_SOURCE_CODE, s);
        write_reg(jct_pkg::REG_TARGET_CODE, t);
        write_reg(jct_pkg::REG_WIDEN_KANA, {2'b00, w});
        cfg_ch.valid <= 1'b0;
    endtask

    // directed stream: byte, end flag and, where obvious, the single result
    typedef struct {
        logic [7:0] b;
        logic       fin;
        int         want;
    } t_row;

    t_row directed[$];

    // mostly well-formed random text for the current source code
    task automatic random_text(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            case (eff(m_src))
                jct_pkg::CODE_EUC: begin
                    if (k < 35) begin
                        send_item(8'($urandom_range(161, 254)), 1'b0);
                        send_item(8'($urandom_range(161, 254)), 1'b0);
                    end else if (k < 60) begin
                        send_item(B_SS2, 1'b0);
                        send_item(8'($urandom_range(161, 223)), 1'b0);
                        if ($urandom_range(1)) begin
                            send_item(B_SS2, 1'b0);
                            send_item($urandom_range(1) ? B_DAKU : B_HAN, 1'b0);
                        end
                    end else if (k < 90) send_item(8'($urandom_range(32, 126)), 1'b0);
                    else if (k < 95) send_item($urandom_range(1) ? B_LF : B_CR, 1'b0);
                    else send_item(8'($urandom_range(255)), 1'b0);
                end
                jct_pkg::CODE_SJIS: begin
                    if (k < 35) begin
                        send_item(is_sjis_lead(8'($urandom_range(129, 159)))
                                  ? 8'($urandom_range(129, 159))
                                  : 8'($urandom_range(224, 239)), 1'b0);
                        send_item(8'($urandom_range(64, 252)), 1'b0);
                    end else if (k < 60) begin
                        send_item(8'($urandom_range(161, 223)), 1'b0);
                        if ($urandom_range(1))
                            send_item($urandom_range(1) ? B_DAKU : B_HAN, 1'b0);
                    end else if (k < 90) send_item(8'($urandom_range(32, 126)), 1'b0);
                    else if (k < 95) send_item($urandom_range(1) ? B_LF : B_CR, 1'b0);
                    else send_item(8'($urandom_range(255)), 1'b0);
                end
                default: begin
                    if (k < 20) begin
                        send_item(B_ESC, 1'b0);
                        case ($urandom_range(3))
                            0: begin send_item("$", 1'b0); send_item("B", 1'b0); end
                            1: begin send_item("(", 1'b0); send_item("J", 1'b0); end
                            2: send_item("K", 1'b0);
                            default: send_item("H", 1'b0);
                        endcase
                    end else if (k < 70) begin
                        send_item(8'($urandom_range(33, 126)), 1'b0);
                    end else if (k < 80) begin
                        send_item($urandom_range(1) ? B_LF : B_CR, 1'b0);
                    end else begin
                        send_item(8'($urandom_range(255)), 1'b0);
                    end
                end
            endcase
        end
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.in_byte = '0;
        in_ch.in_end = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        clear_text_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset codes are shift-jis both ways, so plain bytes pass
        directed = '{
            '{8'd0,   1'b0, 0},   '{8'd127, 1'b0, 127}, '{8'd255, 1'b0, 255},
            '{8'd136, 1'b0, -1},  '{8'd159, 1'b0, -1},   // kanji pair
            '{8'd129, 1'b0, -1},  '{8'd20,  1'b0, -1},   // invalid pair dropped
            '{8'd177, 1'b0, 177}, '{8'd224, 1'b0, -1},  '{8'd0, 1'b1, -1}
        };
        foreach (directed[i]) begin
            send_item(directed[i].b, directed[i].fin);
            if (directed[i].want >= 0 && (expected_bytes.size() == 0 ||
                expected_bytes[$].data != 8'(directed[i].want))) begin
                report_mismatch("directed row", expected_bytes.size(),
                                directed[i].want);
            end
        end
        // kana widening with marks, eol kanji close, escapes
        set_codes(jct_pkg::CODE_SJIS, jct_pkg::CODE_NEW, 1'b0);
        send_item(8'd182, 1'b0); send_item(B_DAKU, 1'b0);
        send_item(8'd202, 1'b0); send_item(B_HAN, 1'b0);
        send_item(8'd179, 1'b0); send_item(B_DAKU, 1'b0);
        send_item(8'd161, 1'b0); send_item(B_LF, 1'b0);
        send_item(8'd223, 1'b0); send_item(8'd0, 1'b1);
        set_codes(jct_pkg::CODE_EUC, jct_pkg::CODE_NEC, 1'b1);
        send_item(B_SS2, 1'b0); send_item(8'd202, 1'b0);
        send_item(B_SS2, 1'b0); send_item(B_HAN, 1'b0);
        send_item(8'd176, 1'b0); send_item(8'd162, 1'b0);
        send_item(B_SS2, 1'b0); send_item(8'd0, 1'b1);

        // random phases over code pairs, extremes and out-of-range codes
        for (int ph = 0; ph < 9; ph++) begin
            jct_pkg::t_code s;
            jct_pkg::t_code t;
            s = (ph < 2) ? 3'(ph * 7) : 3'($urandom_range(7));
            t = (ph < 2) ? 3'(7 - ph * 7) : 3'($urandom_range(7));
            set_codes(s, t, 1'($urandom_range(1)));
            if (ph == 4) quiet_phase = 1'b1;
            if (ph == 6) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (tb_jct_pkg::HOLD_OFF_CYCLES) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            random_text(18);
            quiet_phase = 1'b0;
        end
        drain();

        $display("sent %0d items over several code pairs, checked %0d output bytes",
                 items_sent, bytes_checked);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

### sim.f
rtl/jct_pkg.sv
rtl/jct_if.sv
rtl/japanese_code_transcoder.sv
rtl/jct_checker.sv
bench/tb_channels.sv
bench/tb.sv
